### sv/gbfr_pkg.sv
// Shared constants and types of the binary frame receiver.
package gbfr_pkg;

  localparam int unsigned MAX_PAYLOAD = 40;
  localparam int unsigned RUN_MAX     = 40;

  localparam logic [7:0] SYNC_FIRST  = 8'hB5;
  localparam logic [7:0] SYNC_SECOND = 8'h62;

  localparam int unsigned ID_W   = 16;
  localparam int unsigned LEN_W  = 6;
  localparam int unsigned CNT_W  = 8;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [ID_W-1:0]  POS_ID_RST  = 16'h0102;
  localparam logic [ID_W-1:0]  VEL_ID_RST  = 16'h0112;
  localparam logic [LEN_W-1:0] POS_LEN_RST = 6'd28;
  localparam logic [LEN_W-1:0] VEL_LEN_RST = 6'd36;

  localparam logic [CFG_IDX_W-1:0] REG_POS_ID  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VEL_ID  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POS_LEN = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VEL_LEN = 2'd3;

  localparam logic KIND_POS = 1'b0;
  localparam logic KIND_VEL = 1'b1;

  // Readout request raised by the framer on a good, matching frame.
  typedef struct packed {
    logic             start;
    logic             kind;
    logic [CNT_W-1:0] count;
    logic [LEN_W-1:0] len;
  } run_req_t;

endpackage

### sv/gbfr_store.sv
// Payload store: one write port, one registered read port, per-entry valid bits.
module gbfr_store #(
  parameter int unsigned MaxPayload = gbfr_pkg::MAX_PAYLOAD,
  localparam int unsigned AW = $clog2(MaxPayload)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        wr_en_i,
  input  logic [AW-1:0]               wr_addr_i,
  input  logic [gbfr_pkg::BYTE_W-1:0] wr_data_i,
  input  logic                        rd_en_i,
  input  logic [AW-1:0]               rd_addr_i,
  output logic [gbfr_pkg::BYTE_W-1:0] rd_data_o
);

  logic [gbfr_pkg::BYTE_W-1:0] mem [MaxPayload];
  logic [MaxPayload-1:0]       vld_q;
  logic [gbfr_pkg::BYTE_W-1:0] rd_data_q;
  logic                        rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  // Never-written entries read as zero.
  assign rd_data_o = rd_vld_q ? rd_data_q : '0;

endmodule

### sv/gbfr_framer.sv
// Frame parser: sync hunt, header, payload write, checksum check, counters.
module gbfr_framer #(
  parameter int unsigned MaxPayload = gbfr_pkg::MAX_PAYLOAD,
  localparam int unsigned AW = $clog2(MaxPayload)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        byte_valid_i,
  input  logic [gbfr_pkg::BYTE_W-1:0] byte_i,
  input  logic [gbfr_pkg::ID_W-1:0]   pos_id_i,
  input  logic [gbfr_pkg::ID_W-1:0]   vel_id_i,
  input  logic [gbfr_pkg::LEN_W-1:0]  pos_len_i,
  input  logic [gbfr_pkg::LEN_W-1:0]  vel_len_i,
  output logic                        wr_en_o,
  output logic [AW-1:0]               wr_addr_o,
  output logic [gbfr_pkg::BYTE_W-1:0] wr_data_o,
  output gbfr_pkg::run_req_t          run_o
);

  localparam int unsigned LW = $clog2(MaxPayload + 1);
  localparam int unsigned RunLimit =
      (MaxPayload < gbfr_pkg::RUN_MAX) ? MaxPayload : gbfr_pkg::RUN_MAX;
  localparam logic [gbfr_pkg::LEN_W-1:0] RunLimitL = gbfr_pkg::LEN_W'(RunLimit);

  typedef enum logic [7:0] {
    ST_HUNT  = 8'b0000_0001,
    ST_TYPE1 = 8'b0000_0010,
    ST_TYPE2 = 8'b0000_0100,
    ST_LEN1  = 8'b0000_1000,
    ST_LEN2  = 8'b0001_0000,
    ST_PAY   = 8'b0010_0000,
    ST_CKA   = 8'b0100_0000,
    ST_CKB   = 8'b1000_0000
  } step_e;

  step_e                       step_q, step_d;
  logic                        sync_q, sync_d;
  logic [7:0]                  sum_a_q, sum_a_d;
  logic [7:0]                  sum_b_q, sum_b_d;
  logic [gbfr_pkg::ID_W-1:0]   type_q, type_d;
  logic [7:0]                  len_lo_q, len_lo_d;
  logic [LW-1:0]               len_q, len_d;
  logic [AW-1:0]               offs_q, offs_d;
  logic [gbfr_pkg::CNT_W-1:0]  pos_cnt_q, pos_cnt_d;
  logic [gbfr_pkg::CNT_W-1:0]  vel_cnt_q, vel_cnt_d;

  logic [7:0]                  acc_a;
  logic [15:0]                 full_len;
  logic [LW-1:0]               offs_next;
  logic                        process;
  logic [gbfr_pkg::LEN_W-1:0]  pos_n, vel_n;

  assign acc_a     = sum_a_q + byte_i;
  assign full_len  = {byte_i, len_lo_q};
  assign offs_next = LW'(offs_q) + LW'(1);
  assign pos_n     = (pos_len_i > RunLimitL) ? RunLimitL : pos_len_i;
  assign vel_n     = (vel_len_i > RunLimitL) ? RunLimitL : vel_len_i;

  always_comb begin
    step_d    = step_q;
    sync_d    = sync_q;
    sum_a_d   = sum_a_q;
    sum_b_d   = sum_b_q;
    type_d    = type_q;
    len_lo_d  = len_lo_q;
    len_d     = len_q;
    offs_d    = offs_q;
    pos_cnt_d = pos_cnt_q;
    vel_cnt_d = vel_cnt_q;
    wr_en_o   = 1'b0;
    wr_addr_o = offs_q;
    wr_data_o = byte_i;
    run_o     = '0;
    process   = 1'b0;

    if (byte_valid_i) begin
      if (byte_i == gbfr_pkg::SYNC_FIRST) begin
        sync_d  = 1'b1;
        process = (step_q != ST_HUNT);
      end else if (sync_q && byte_i == gbfr_pkg::SYNC_SECOND) begin
        // Restart framing from any step.
        sync_d = 1'b0;
        step_d = ST_TYPE1;
      end else begin
        sync_d  = 1'b0;
        process = 1'b1;
      end
    end

    if (process) begin
      case (step_q)
        ST_TYPE1: begin
          sum_a_d = byte_i;
          sum_b_d = byte_i;
          type_d  = {byte_i, 8'h00};
          step_d  = ST_TYPE2;
        end
        ST_TYPE2: begin
          sum_a_d = acc_a;
          sum_b_d = sum_b_q + acc_a;
          type_d  = {type_q[15:8], byte_i};
          step_d  = ST_LEN1;
        end
        ST_LEN1: begin
          sum_a_d  = acc_a;
          sum_b_d  = sum_b_q + acc_a;
          len_lo_d = byte_i;
          step_d   = ST_LEN2;
        end
        ST_LEN2: begin
          sum_a_d = acc_a;
          sum_b_d = sum_b_q + acc_a;
          offs_d  = '0;
          len_d   = LW'(full_len);
          if (full_len > 16'(MaxPayload)) begin
            step_d = ST_HUNT;
          end else if (full_len == 16'd0) begin
            step_d = ST_CKA;
          end else begin
            step_d = ST_PAY;
          end
        end
        ST_PAY: begin
          sum_a_d = acc_a;
          sum_b_d = sum_b_q + acc_a;
          wr_en_o = 1'b1;
          offs_d  = AW'(offs_next);
          if (offs_next >= len_q) begin
            step_d = ST_CKA;
          end
        end
        ST_CKA: begin
          step_d = (sum_a_q == byte_i) ? ST_CKB : ST_HUNT;
        end
        ST_CKB: begin
          step_d = ST_HUNT;
          if (sum_b_q == byte_i) begin
            if (type_q == pos_id_i) begin
              pos_cnt_d   = pos_cnt_q + 1'b1;
              run_o.start = (pos_n != '0);
              run_o.kind  = gbfr_pkg::KIND_POS;
              run_o.count = pos_cnt_d;
              run_o.len   = pos_n;
            end else if (type_q == vel_id_i) begin
              vel_cnt_d   = vel_cnt_q + 1'b1;
              run_o.start = (vel_n != '0);
              run_o.kind  = gbfr_pkg::KIND_VEL;
              run_o.count = vel_cnt_d;
              run_o.len   = vel_n;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q    <= ST_HUNT;
      sync_q    <= 1'b0;
      sum_a_q   <= '0;
      sum_b_q   <= '0;
      type_q    <= '0;
      len_lo_q  <= '0;
      len_q     <= '0;
      offs_q    <= '0;
      pos_cnt_q <= '0;
      vel_cnt_q <= '0;
    end else begin
      step_q    <= step_d;
      sync_q    <= sync_d;
      sum_a_q   <= sum_a_d;
      sum_b_q   <= sum_b_d;
      type_q    <= type_d;
      len_lo_q  <= len_lo_d;
      len_q     <= len_d;
      offs_q    <= offs_d;
      pos_cnt_q <= pos_cnt_d;
      vel_cnt_q <= vel_cnt_d;
    end
  end

endmodule

### sv/gbfr_readout.sv
// Readout sequencer: walks the store for one run and drives the output register.
module gbfr_readout #(
  parameter int unsigned MaxPayload = gbfr_pkg::MAX_PAYLOAD,
  localparam int unsigned AW = $clog2(MaxPayload)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  gbfr_pkg::run_req_t          run_i,
  output logic                        busy_o,
  output logic                        rd_en_o,
  output logic [AW-1:0]               rd_addr_o,
  input  logic [gbfr_pkg::BYTE_W-1:0] rd_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        out_kind_o,
  output logic [gbfr_pkg::LEN_W-1:0]  out_offset_o,
  output logic [gbfr_pkg::BYTE_W-1:0] out_value_o,
  output logic [gbfr_pkg::CNT_W-1:0]  out_count_o,
  output logic                        out_last_o
);

  logic                        active_q;
  logic                        kind_q;
  logic [gbfr_pkg::CNT_W-1:0]  count_q;
  logic [gbfr_pkg::LEN_W-1:0]  len_q;
  logic [gbfr_pkg::LEN_W-1:0]  next_k_q;
  logic                        pend_q;
  logic [gbfr_pkg::LEN_W-1:0]  pend_k_q;
  logic                        pend_last;

  logic                        ov_q;
  logic                        okind_q;
  logic [gbfr_pkg::LEN_W-1:0]  ooff_q;
  logic [gbfr_pkg::BYTE_W-1:0] oval_q;
  logic [gbfr_pkg::CNT_W-1:0]  ocnt_q;
  logic                        olast_q;

  // Issue a read only when the output register is free by the time data lands.
  assign rd_en_o   = active_q && !pend_q && (next_k_q < len_q) && (!ov_q || out_ready_i);
  assign rd_addr_o = AW'(next_k_q);
  assign pend_last = (pend_k_q + 1'b1 == len_q);
  assign busy_o    = active_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      pend_q   <= 1'b0;
      next_k_q <= '0;
      ov_q     <= 1'b0;
    end else begin
      if (run_i.start) begin
        active_q <= 1'b1;
        next_k_q <= '0;
      end else if (pend_q && pend_last) begin
        active_q <= 1'b0;
      end
      if (rd_en_o) begin
        next_k_q <= next_k_q + 1'b1;
      end
      pend_q <= rd_en_o;
      if (pend_q) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (run_i.start) begin
      kind_q  <= run_i.kind;
      count_q <= run_i.count;
      len_q   <= run_i.len;
    end
    if (rd_en_o) begin
      pend_k_q <= next_k_q;
    end
    if (pend_q) begin
      okind_q <= kind_q;
      ooff_q  <= pend_k_q;
      oval_q  <= rd_data_i;
      ocnt_q  <= count_q;
      olast_q <= pend_last;
    end
  end

  assign out_valid_o  = ov_q;
  assign out_kind_o   = okind_q;
  assign out_offset_o = ooff_q;
  assign out_value_o  = oval_q;
  assign out_count_o  = ocnt_q;
  assign out_last_o   = olast_q;

endmodule

### sv/gnss_binary_frame_receiver.sv
// Top level of the binary frame receiver: config registers and block wiring.
//
// Usage:
//   Received bytes enter on the s_axis channel, one byte per request, and are
//   taken one per cycle while no readout run is in progress. A frame starts
//   with the sync pair 0xB5 0x62, carries a type word, a little-endian length,
//   the payload and two Fletcher checksum bytes. Payload bytes go into the
//   payload store as they arrive.
//   On a good frame whose type matches the position or velocity id, the first
//   copy-length bytes of the store (at most MaxPayload) go out on m_axis, one
//   byte per request, tagged with the kind (tuser) and that kind's frame
//   counter; tlast marks the final byte of the run. Store reads start once the
//   run is registered after the second checksum byte, pass through the store's
//   registered read and the single output register, and do not overlap. While a
//   run is in progress s_axis_tready stays low, until the last store read has
//   landed in the output register. A stalled m_axis holds it and pauses reads.
//   Reset returns to sync hunting, clears counters and checksum state, loads
//   the default ids and copy lengths, and marks every store entry as zero.
//   Configuration writes take effect at once; the user must make them while
//   idle, as the block does not enforce it.
module gnss_binary_frame_receiver #(
  parameter int unsigned MaxPayload = gbfr_pkg::MAX_PAYLOAD
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input bytes
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  // Emitted payload bytes
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [5:0] byte_offset, [13:6] byte_value,
                                      // [21:14] frame_count, [23:22] zero
  output logic        m_axis_tuser,   // [0] msg_kind
  output logic        m_axis_tlast,   // last_byte
  // Configuration writes
  input  logic                            cfg_we_i,
  input  logic [gbfr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [gbfr_pkg::ID_W-1:0]       cfg_data_i
);

  localparam int unsigned AW = $clog2(MaxPayload);

  logic [gbfr_pkg::ID_W-1:0]   pos_id_q, vel_id_q;
  logic [gbfr_pkg::LEN_W-1:0]  pos_len_q, vel_len_q;

  logic                        in_acc;
  logic                        busy;
  logic                        wr_en;
  logic [AW-1:0]               wr_addr;
  logic [gbfr_pkg::BYTE_W-1:0] wr_data;
  logic                        rd_en;
  logic [AW-1:0]               rd_addr;
  logic [gbfr_pkg::BYTE_W-1:0] rd_data;
  gbfr_pkg::run_req_t          run;

  logic [gbfr_pkg::LEN_W-1:0]  o_off;
  logic [gbfr_pkg::BYTE_W-1:0] o_val;
  logic [gbfr_pkg::CNT_W-1:0]  o_cnt;

  // Register file: ids take the full word, copy lengths the low bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_id_q  <= gbfr_pkg::POS_ID_RST;
      vel_id_q  <= gbfr_pkg::VEL_ID_RST;
      pos_len_q <= gbfr_pkg::POS_LEN_RST;
      vel_len_q <= gbfr_pkg::VEL_LEN_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        gbfr_pkg::REG_POS_ID:  pos_id_q  <= cfg_data_i;
        gbfr_pkg::REG_VEL_ID:  vel_id_q  <= cfg_data_i;
        gbfr_pkg::REG_POS_LEN: pos_len_q <= cfg_data_i[gbfr_pkg::LEN_W-1:0];
        gbfr_pkg::REG_VEL_LEN: vel_len_q <= cfg_data_i[gbfr_pkg::LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Hold input while a readout run owns the store.
  assign s_axis_tready = !busy;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  gbfr_framer #(
    .MaxPayload (MaxPayload)
  ) u_framer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (in_acc),
    .byte_i       (s_axis_tdata),
    .pos_id_i     (pos_id_q),
    .vel_id_i     (vel_id_q),
    .pos_len_i    (pos_len_q),
    .vel_len_i    (vel_len_q),
    .wr_en_o      (wr_en),
    .wr_addr_o    (wr_addr),
    .wr_data_o    (wr_data),
    .run_o        (run)
  );

  gbfr_store #(
    .MaxPayload (MaxPayload)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  gbfr_readout #(
    .MaxPayload (MaxPayload)
  ) u_readout (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .run_i        (run),
    .busy_o       (busy),
    .rd_en_o      (rd_en),
    .rd_addr_o    (rd_addr),
    .rd_data_i    (rd_data),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_kind_o   (m_axis_tuser),
    .out_offset_o (o_off),
    .out_value_o  (o_val),
    .out_count_o  (o_cnt),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, o_cnt, o_val, o_off};

endmodule

### tb/gnss_binary_frame_receiver_tb.sv
// Self-checking testbench of the binary frame receiver: byte stream in, payload readout checked.
module gnss_binary_frame_receiver_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES  = 6;

  typedef enum logic [2:0] {
    ST_HUNT, ST_TYPE_HI, ST_TYPE_LO, ST_LEN_LO, ST_LEN_HI, ST_PAYLOAD, ST_CK_A, ST_CK_B
  } frame_step_e;

  // One emitted payload byte.
  typedef struct packed {
    logic                       kind;
    logic [gbfr_pkg::LEN_W-1:0] offset;
    logic [7:0]                 value;
    logic [gbfr_pkg::CNT_W-1:0] count;
    logic                       last;
  } readout_byte_t;

  // Tracks the framer and holds the readout bytes still to come.
  class readout_tracker;
    logic [gbfr_pkg::ID_W-1:0]  pos_id, vel_id;
    logic [gbfr_pkg::LEN_W-1:0] pos_len, vel_len;
    bit                         sync_seen;
    frame_step_e                step;
    logic [7:0]                 sum_a, sum_b;
    logic [15:0]                type_w, pay_len;
    int unsigned                wr_off;
    logic [7:0]                 store [gbfr_pkg::MAX_PAYLOAD];
    logic [gbfr_pkg::CNT_W-1:0] pos_cnt, vel_cnt;
    readout_byte_t              expected_bytes [$];
    int unsigned                mismatch_cnt;

    function new();
      pos_id    = gbfr_pkg::POS_ID_RST;
      vel_id    = gbfr_pkg::VEL_ID_RST;
      pos_len   = gbfr_pkg::POS_LEN_RST;
      vel_len   = gbfr_pkg::VEL_LEN_RST;
      sync_seen = 1'b0;
      step      = ST_HUNT;
      sum_a     = '0;
      sum_b     = '0;
      type_w    = '0;
      pay_len   = '0;
      wr_off    = 0;
      foreach (store[i]) store[i] = '0;
      pos_cnt   = '0;
      vel_cnt   = '0;
      mismatch_cnt = 0;
    endfunction

    function void set_reg(logic [gbfr_pkg::CFG_IDX_W-1:0] idx,
                          logic [gbfr_pkg::ID_W-1:0] data);
      case (idx)
        gbfr_pkg::REG_POS_ID:  pos_id  = data;
        gbfr_pkg::REG_VEL_ID:  vel_id  = data;
        gbfr_pkg::REG_POS_LEN: pos_len = data[gbfr_pkg::LEN_W-1:0];
        gbfr_pkg::REG_VEL_LEN: vel_len = data[gbfr_pkg::LEN_W-1:0];
        default: ;
      endcase
    endfunction

    function void add_sum(logic [7:0] b);
      sum_a = sum_a + b;
      sum_b = sum_b + sum_a;
    endfunction

    // Queue the run of stored bytes, clipped to the store size.
    function void queue_run(logic kind, logic [gbfr_pkg::LEN_W-1:0] len,
                            logic [gbfr_pkg::CNT_W-1:0] cnt);
      int unsigned n;
      readout_byte_t rb;
      n = (len > gbfr_pkg::MAX_PAYLOAD) ? gbfr_pkg::MAX_PAYLOAD : len;
      for (int unsigned k = 0; k < n; k++) begin
        rb.kind   = kind;
        rb.offset = k[gbfr_pkg::LEN_W-1:0];
        rb.value  = store[k];
        rb.count  = cnt;
        rb.last   = (k + 1 == n);
        expected_bytes.push_back(rb);
      end
    endfunction

    // Advance the framer by one accepted byte.
    function void take_rx_byte(logic [7:0] b);
      if (b == gbfr_pkg::SYNC_FIRST) begin
        sync_seen = 1'b1;
        if (step == ST_HUNT) return;
      end else if (sync_seen && b == gbfr_pkg::SYNC_SECOND) begin
        // Sync pair restarts framing from any step.
        step      = ST_TYPE_HI;
        sync_seen = 1'b0;
        return;
      end else begin
        sync_seen = 1'b0;
      end

      case (step)
        ST_TYPE_HI: begin
          sum_a  = b;
          sum_b  = b;
          type_w = {b, 8'h00};
          step   = ST_TYPE_LO;
        end
        ST_TYPE_LO: begin
          add_sum(b);
          type_w[7:0] = b;
          step = ST_LEN_LO;
        end
        ST_LEN_LO: begin
          add_sum(b);
          pay_len = {8'h00, b};
          step = ST_LEN_HI;
        end
        ST_LEN_HI: begin
          add_sum(b);
          pay_len[15:8] = b;
          wr_off = 0;
          if (pay_len > gbfr_pkg::MAX_PAYLOAD) step = ST_HUNT;
          else if (pay_len == 0)               step = ST_CK_A;
          else                                 step = ST_PAYLOAD;
        end
        ST_PAYLOAD: begin
          add_sum(b);
          if (wr_off < gbfr_pkg::MAX_PAYLOAD) store[wr_off] = b;
          wr_off++;
          if (wr_off >= pay_len || wr_off >= gbfr_pkg::MAX_PAYLOAD) step = ST_CK_A;
        end
        ST_CK_A: step = (sum_a == b) ? ST_CK_B : ST_HUNT;
        ST_CK_B: begin
          step = ST_HUNT;
          if (sum_b == b) begin
            // Position wins when both ids match.
            if (type_w == pos_id) begin
              pos_cnt++;
              queue_run(gbfr_pkg::KIND_POS, pos_len, pos_cnt);
            end else if (type_w == vel_id) begin
              vel_cnt++;
              queue_run(gbfr_pkg::KIND_VEL, vel_len, vel_cnt);
            end
          end
        end
        default: ;
      endcase
    endfunction

    // Compare one accepted readout byte with the oldest one due.
    function void match_readout(readout_byte_t got);
      readout_byte_t want;
      if (expected_bytes.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected readout: kind=%0d off=%0d val=%02h cnt=%0d last=%0d",
                   got.kind, got.offset, got.value, got.count, got.last);
        return;
      end
      want = expected_bytes.pop_front();
      if (got.kind !== want.kind || got.offset !== want.offset || got.value !== want.value ||
          got.count !== want.count || got.last !== want.last) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) begin
          $display("readout mismatch: exp kind=%0d off=%0d val=%02h cnt=%0d last=%0d",
                   want.kind, want.offset, want.value, want.count, want.last);
          $display("                  got kind=%0d off=%0d val=%02h cnt=%0d last=%0d",
                   got.kind, got.offset, got.value, got.count, got.last);
        end
      end
    endfunction
  endclass

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;
  logic                           cfg_we_i    = 1'b0;
  logic [gbfr_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [gbfr_pkg::ID_W-1:0]      cfg_data_i  = '0;

  readout_tracker readout = new();
  logic [7:0]     tx_q [$];
  bit             gaps_on = 1'b1;
  int unsigned    quiet_cycles = 0;

  always #6 clk_i = ~clk_i;

  gnss_binary_frame_receiver u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Readout side: stall in random bursts while gaps are enabled.
  always begin
    @(posedge clk_i);
    if (gaps_on && $urandom_range(0, 7) == 0) begin
      m_axis_tready <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    m_axis_tready <= 1'b1;
  end

  // Sample at the falling edge: values there are the ones seen at the next rising edge.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready)
        readout.match_readout(readout_byte_t'({m_axis_tuser, m_axis_tdata[5:0],
                                               m_axis_tdata[13:6], m_axis_tdata[21:14],
                                               m_axis_tlast}));
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no request moved for %0d cycles", WATCHDOG_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // Queue one frame: sync pair, type, length, payload, checksum; keep < 0 sends it whole.
  function automatic void queue_frame(logic [15:0] id, logic [15:0] len, bit corrupt, int keep);
    logic [7:0]  frame_bytes [$];
    logic [7:0]  ck_a, ck_b;
    int unsigned n;
    frame_bytes = {id[15:8], id[7:0], len[7:0], len[15:8]};
    n = (len > gbfr_pkg::MAX_PAYLOAD) ? 0 : int'(len);
    repeat (n) frame_bytes.push_back(8'($urandom));
    ck_a = '0;
    ck_b = '0;
    foreach (frame_bytes[i]) begin
      ck_a = ck_a + frame_bytes[i];
      ck_b = ck_b + ck_a;
    end
    if (len <= gbfr_pkg::MAX_PAYLOAD) begin
      frame_bytes.push_back(ck_a);
      frame_bytes.push_back(ck_b);
      if (corrupt)
        frame_bytes[frame_bytes.size() - 1 - $urandom_range(0, 1)] ^=
            8'h01 << $urandom_range(0, 7);
    end
    tx_q.push_back(gbfr_pkg::SYNC_FIRST);
    tx_q.push_back(gbfr_pkg::SYNC_SECOND);
    foreach (frame_bytes[i])
      if (keep < 0 || i < keep) tx_q.push_back(frame_bytes[i]);
  endfunction

  // Mostly well-formed frames of the forwarded kinds; some noise, cut-off and bad frames.
  function automatic void queue_random_chunk();
    int unsigned pick, lsel;
    logic [15:0] id, len;
    int          keep;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      repeat ($urandom_range(1, 6)) tx_q.push_back(8'($urandom));
      return;
    end
    case ($urandom_range(0, 4))
      0, 1:    id = readout.pos_id;
      2, 3:    id = readout.vel_id;
      default: id = 16'($urandom);
    endcase
    lsel = $urandom_range(0, 9);
    if (lsel < 7)      len = 16'($urandom_range(0, 8));
    else if (lsel < 9) len = 16'($urandom_range(9, gbfr_pkg::MAX_PAYLOAD));
    else               len = 16'($urandom_range(gbfr_pkg::MAX_PAYLOAD + 1, 65535));
    // Cut a frame short so the next sync pair lands inside it.
    keep = (pick < 22) ?
        $urandom_range(1, 5 + ((len <= gbfr_pkg::MAX_PAYLOAD) ? int'(len) : 0)) : -1;
    queue_frame(id, len, $urandom_range(0, 9) == 0, keep);
  endfunction

  task automatic send_byte(input logic [7:0] b);
    logic taken;
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do begin
      @(negedge clk_i);
      taken = s_axis_tready;
      @(posedge clk_i);
    end while (!taken);
    readout.take_rx_byte(b);
  endtask

  task automatic send_stream();
    while (tx_q.size() != 0) send_byte(tx_q.pop_front());
  endtask

  task automatic run_phase(input int unsigned n_items);
    while (tx_q.size() < n_items) queue_random_chunk();
    send_stream();
  endtask

  // Drop the request, drain the readout, then let the block settle.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (readout.expected_bytes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [gbfr_pkg::CFG_IDX_W-1:0] idx,
                           input logic [gbfr_pkg::ID_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    readout.set_reg(idx, data);
  endtask

  task automatic load_settings(input logic [gbfr_pkg::ID_W-1:0] pid,
                               input logic [gbfr_pkg::ID_W-1:0] vid,
                               input logic [gbfr_pkg::ID_W-1:0] plen,
                               input logic [gbfr_pkg::ID_W-1:0] vlen);
    write_reg(gbfr_pkg::REG_POS_ID, pid);
    write_reg(gbfr_pkg::REG_VEL_ID, vid);
    write_reg(gbfr_pkg::REG_POS_LEN, plen);
    write_reg(gbfr_pkg::REG_VEL_LEN, vlen);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Copy length in the low bits, random junk above that the register drops.
  function automatic logic [gbfr_pkg::ID_W-1:0] len_word(
      input logic [gbfr_pkg::LEN_W-1:0] len);
    return {10'($urandom), len};
  endfunction

  initial begin
    logic [gbfr_pkg::ID_W-1:0] same_id;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: byte extremes, empty payload, doubled sync byte, oversized length.
    tx_q = {8'h00, 8'hFF};
    queue_frame(gbfr_pkg::POS_ID_RST, 16'd0, 1'b0, -1);
    tx_q.push_back(gbfr_pkg::SYNC_FIRST);
    queue_frame(gbfr_pkg::VEL_ID_RST, 16'd1, 1'b0, -1);
    queue_frame(16'h0000, 16'(gbfr_pkg::MAX_PAYLOAD + 1), 1'b0, -1);
    send_stream();

    // Extreme ids, shortest nonzero and full-store copy lengths.
    wait_idle();
    load_settings(16'h0000, 16'hFFFF, len_word(6'd1), len_word(6'd40));
    run_phase(65);

    // Both ids equal; position copy length beyond the store, velocity zero.
    same_id = 16'($urandom);
    wait_idle();
    load_settings(same_id, same_id, len_word(6'd63), len_word(6'd0));
    run_phase(65);

    // Zero position copy length, saturated velocity copy length, no idling.
    wait_idle();
    load_settings(16'($urandom), 16'($urandom), len_word(6'd0), len_word(6'd63));
    gaps_on = 1'b0;
    run_phase(65);

    // Random settings, idling again, then a final stretch with none.
    wait_idle();
    load_settings(16'($urandom), 16'($urandom), len_word(6'($urandom_range(1, 40))),
                  len_word(6'($urandom_range(1, 40))));
    gaps_on = 1'b1;
    run_phase(65);
    gaps_on = 1'b0;
    run_phase(55);

    wait_idle();
    if (readout.mismatch_cnt == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

### files.f
sv/gbfr_pkg.sv
sv/gbfr_store.sv
sv/gbfr_framer.sv
sv/gbfr_readout.sv
sv/gnss_binary_frame_receiver.sv
tb/gnss_binary_frame_receiver_tb.sv
